### rtl/mode_display_counter_mux_macros.svh
// ----------------------------------------------------------------------------
// mode display counter mux assertion macros
// shared concurrent check forms, sampled on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MODE_DISPLAY_COUNTER_MUX_MACROS_SVH
`define MODE_DISPLAY_COUNTER_MUX_MACROS_SVH

// condition that holds at every clock edge out of reset
`define MDCM_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that forces a consequence at the next clock edge
`define MDCM_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mdcm_pkg.sv
// ----------------------------------------------------------------------------
// mdcm_pkg
// shared widths, codes, segment tables and bcd helpers for the display mux
// ----------------------------------------------------------------------------
package mdcm_pkg;

	localparam int OP_W     = 3;
	localparam int RW_W     = 31;
	localparam int DEN_W    = 4;
	localparam int SEG_W    = 7;
	localparam int MODE_W   = 2;
	localparam int XPER_W   = 10;
	localparam int CPER_W   = 10;
	localparam int ZPER_W   = 11;
	localparam int LIM_W    = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 14;
	localparam int BCD_W    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_SEL_X  = 3'd1,
		OP_SEL_Y  = 3'd2,
		OP_SEL_Z  = 3'd3,
		OP_TOGGLE = 3'd4
	} op_e;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE = 2'd0,
		MODE_X    = 2'd1,
		MODE_Y    = 2'd2,
		MODE_Z    = 2'd3
	} mode_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_PERIOD     = 2'd0,
		REG_COUNT_PERIOD = 2'd1,
		REG_Z_PERIOD     = 2'd2,
		REG_COUNT_LIMIT  = 2'd3
	} cfg_reg_e;

	// reset values of the registers
	localparam logic [XPER_W-1:0] X_PERIOD_RST     = 10'd500;
	localparam logic [CPER_W-1:0] COUNT_PERIOD_RST = 10'd10;
	localparam logic [ZPER_W-1:0] Z_PERIOD_RST     = 11'd1200;
	localparam logic [LIM_W-1:0]  COUNT_LIMIT_RST  = 14'd9999;

	localparam logic [LIM_W-1:0] CNT_MAX = 14'd9999;
	localparam logic [5:0]       X_BASE  = 6'd20;

	// rw mod 999: quotient estimate by reciprocal, low 11 bits finish the job
	localparam int               Z_SHIFT  = 41;
	localparam logic [31:0]      RECIP_Z  = 32'((64'd1 << Z_SHIFT) / 64'd999);
	localparam logic [10:0]      Z_MOD_11 = 11'd999;

	// segment table indexes for the non-digit glyphs
	localparam logic [4:0] SEG_A    = 5'd10;
	localparam logic [4:0] SEG_F    = 5'd15;
	localparam logic [4:0] SEG_DASH = 5'd16;

	// front pipeline to state stage
	typedef struct packed {
		logic        valid;
		op_e         op;
		logic [7:0]  x_bcd;
		logic [11:0] z_bcd;
	} front_item_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [4:0] idx);
		logic [SEG_W-1:0] s;
		case (idx)
			5'd0:    s = 7'h01;
			5'd1:    s = 7'h4F;
			5'd2:    s = 7'h12;
			5'd3:    s = 7'h06;
			5'd4:    s = 7'h4C;
			5'd5:    s = 7'h24;
			5'd6:    s = 7'h20;
			5'd7:    s = 7'h0F;
			5'd8:    s = 7'h00;
			5'd9:    s = 7'h04;
			5'd10:   s = 7'h08;
			5'd11:   s = 7'h60;
			5'd12:   s = 7'h31;
			5'd13:   s = 7'h42;
			5'd14:   s = 7'h30;
			5'd15:   s = 7'h38;
			default: s = 7'h7E;
		endcase
		return s;
	endfunction

	function automatic logic [DEN_W-1:0] strobe_of(input logic [1:0] pos);
		logic [DEN_W-1:0] s;
		case (pos)
			2'd0:    s = 4'hE;
			2'd1:    s = 4'hD;
			2'd2:    s = 4'hB;
			default: s = 4'h7;
		endcase
		return s;
	endfunction

	// one double-dabble step: adjust every digit, then shift in one bit
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] acc, input logic b);
		logic [BCD_W-1:0] t;
		t = acc;
		for (int d = 0; d < 4; d++) begin
			if (t[4*d +: 4] >= 4'd5)
				t[4*d +: 4] = t[4*d +: 4] + 4'd3;
		end
		return {t[BCD_W-2:0], b};
	endfunction

	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		logic             c;
		r = v;
		c = 1'b1;
		for (int d = 0; d < 4; d++) begin
			if (c) begin
				if (r[4*d +: 4] == 4'd9) begin
					r[4*d +: 4] = 4'd0;
				end else begin
					r[4*d +: 4] = r[4*d +: 4] + 4'd1;
					c = 1'b0;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [BCD_W-1:0] bcd_dec(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		logic             b;
		r = v;
		b = 1'b1;
		for (int d = 0; d < 4; d++) begin
			if (b) begin
				if (r[4*d +: 4] == 4'd0) begin
					r[4*d +: 4] = 4'd9;
				end else begin
					r[4*d +: 4] = r[4*d +: 4] - 4'd1;
					b = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage

### rtl/mdcm_in_if.sv
// ----------------------------------------------------------------------------
// mdcm_in_if
// event channel: operation code and random source word
// ----------------------------------------------------------------------------
interface mdcm_in_if;
	import mdcm_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [RW_W-1:0]     random_word;

	modport source (output valid, operation, random_word, input ready);
	modport sink   (input valid, operation, random_word, output ready);
endinterface

### rtl/mdcm_out_if.sv
// ----------------------------------------------------------------------------
// mdcm_out_if
// display channel: digit strobes, segment pattern and active mode
// ----------------------------------------------------------------------------
interface mdcm_out_if;
	import mdcm_pkg::*;

	logic                valid;
	logic                ready;
	logic [DEN_W-1:0]    digit_enable;
	logic [SEG_W-1:0]    segments;
	logic [MODE_W-1:0]   active_mode;

	modport source (output valid, digit_enable, segments, active_mode, input ready);
	modport sink   (input valid, digit_enable, segments, active_mode, output ready);
endinterface

### rtl/mdcm_front.sv
// ----------------------------------------------------------------------------
// mdcm_front
// four-stage front pipeline: random word mod 31 and mod 999, then to bcd
// ----------------------------------------------------------------------------
module mdcm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	mdcm_in_if.sink               ev,
	output mdcm_pkg::front_item_t item,
	input  logic                  item_ready
);
	import mdcm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	op_e             op_s1, op_s2, op_s3, op_s4;
	logic [RW_W-1:0] rw_s1;
	logic [4:0]      xr_s2, xr_s3;
	logic [21:0]     qz_s2;
	logic [10:0]     rwlo_s2;
	logic [9:0]      zr_s3;
	logic [7:0]      xbcd_s4;
	logic [11:0]     zbcd_s4;

	// stage 2 logic
	logic [7:0]  xsum;
	logic [5:0]  xfold;
	logic [4:0]  xr;
	logic [62:0] prod;

	// stage 3 logic
	logic [10:0] zm;
	logic [10:0] zraw;
	logic [9:0]  zr;

	// stage 4 logic
	logic [9:0]       zv;
	logic [5:0]       xv;
	logic [BCD_W-1:0] zacc;
	logic [BCD_W-1:0] xacc;

	// a stage takes a new item when empty or when its item moves on
	assign adv4     = !v_s4 || item_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign ev.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= ev.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// 2^5 is 1 mod 31, so 5-bit chunks add up to the same residue
	always_comb begin
		xsum = 8'(rw_s1[4:0]) + 8'(rw_s1[9:5]) + 8'(rw_s1[14:10]) + 8'(rw_s1[19:15])
			+ 8'(rw_s1[24:20]) + 8'(rw_s1[29:25]) + 8'(rw_s1[30]);
		xfold = 6'(xsum[4:0]) + 6'(xsum[7:5]);
		xr = (xfold >= 6'd31) ? 5'(xfold - 6'd31) : xfold[4:0];
		prod = 63'(rw_s1) * 63'(RECIP_Z);
	end

	// quotient estimate is exact or one short: remainder below 2 * 999
	always_comb begin
		zm = qz_s2[10:0] * Z_MOD_11;
		zraw = rwlo_s2 - zm;
		zr = (zraw >= Z_MOD_11) ? 10'(zraw - Z_MOD_11) : zraw[9:0];
	end

	always_comb begin
		zv = zr_s3 + 10'd1;
		xv = X_BASE + {1'b0, xr_s3};
		zacc = {13'b0, zv[9:7]};
		for (int i = 6; i >= 0; i--)
			zacc = dd_step(zacc, zv[i]);
		xacc = {13'b0, xv[5:3]};
		for (int i = 2; i >= 0; i--)
			xacc = dd_step(xacc, xv[i]);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1 <= op_e'(ev.operation);
			rw_s1 <= ev.random_word;
		end
		if (adv2) begin
			op_s2   <= op_s1;
			xr_s2   <= xr;
			qz_s2   <= prod[62:Z_SHIFT];
			rwlo_s2 <= rw_s1[10:0];
		end
		if (adv3) begin
			op_s3 <= op_s2;
			xr_s3 <= xr_s2;
			zr_s3 <= zr;
		end
		if (adv4) begin
			op_s4   <= op_s3;
			xbcd_s4 <= xacc[7:0];
			zbcd_s4 <= zacc[11:0];
		end
	end

	assign item.valid = v_s4;
	assign item.op    = op_s4;
	assign item.x_bcd = xbcd_s4;
	assign item.z_bcd = zbcd_s4;

endmodule

### rtl/mode_display_counter_mux.sv
// ----------------------------------------------------------------------------
// mode_display_counter_mux
// four-digit multiplexed seven-segment driver with random and counter modes
// ----------------------------------------------------------------------------
//  channel    dir   handshake      payload
//  event_ch   in    valid/ready    operation[2:0], random_word[30:0]
//  disp_ch    out   valid/ready    digit_enable[3:0], segments[6:0], active_mode[1:0]
//  cfg        in    cfg_wr_en      cfg_index[1:0], cfg_wdata[13:0]
//
//  one item per cycle sustained while disp_ch is ready; a taken item passes
//  the front stages for the remainders and bcd, then the state update that
//  loads the result register
//  reset clears mode, scan, direction, prescalers, values and all valids
//  the limit in bcd follows a count_limit write via lim_hi_q, then lim_bcd_q
//  each stage holds while the next one holds, so bubbles close up under a
//  stalled display and new items keep coming in until all stages are full
// ----------------------------------------------------------------------------
`include "mode_display_counter_mux_macros.svh"

module mode_display_counter_mux (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mdcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mdcm_pkg::CFG_W-1:0]       cfg_wdata,
	mdcm_in_if.sink                          event_ch,
	mdcm_out_if.source                       disp_ch
);
	import mdcm_pkg::*;

	// configuration registers
	logic [XPER_W-1:0] x_period_q;
	logic [CPER_W-1:0] count_period_q;
	logic [ZPER_W-1:0] z_period_q;
	logic [LIM_W-1:0]  count_limit_q;

	// clamped limit, binary and bcd, two-step conversion
	logic [LIM_W-1:0]  lim_c;
	logic [BCD_W-1:0]  lim_acc_a;
	logic [BCD_W-1:0]  lim_acc_b;
	logic [LIM_W-1:0]  lim_bin_q;
	logic [BCD_W-1:0]  lim_hi_q;
	logic [6:0]        lim_lo_q;
	logic [BCD_W-1:0]  lim_bcd_q;

	// display state
	mode_e             mode_q, mode_n;
	logic [1:0]        scan_q, scan_n;
	logic              down_q, down_n;
	logic [XPER_W-1:0] xpre_q, xpre_n;
	logic [CPER_W-1:0] cpre_q, cpre_n;
	logic [ZPER_W-1:0] zpre_q, zpre_n;
	logic [LIM_W-1:0]  cnt_q, cnt_n;
	logic [BCD_W-1:0]  cbcd_q, cbcd_n;
	logic [7:0]        xbcd_q, xbcd_n;
	logic [11:0]       zbcd_q, zbcd_n;

	// prescaler next counts, one bit wider so the compare cannot wrap
	logic [XPER_W:0]   x_next;
	logic [CPER_W:0]   c_next;
	logic [ZPER_W:0]   z_next;

	// result register
	logic              out_v_s5;
	logic [DEN_W-1:0]  den_s5;
	logic [SEG_W-1:0]  seg_s5;
	mode_e             mode_s5;
	logic [DEN_W-1:0]  den_n;
	logic [4:0]        seg_idx;

	front_item_t       fr;
	logic              adv5;
	logic              take;

	mdcm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (event_ch),
		.item       (fr),
		.item_ready (adv5)
	);

	// result register frees up when empty or being read
	assign adv5 = !out_v_s5 || disp_ch.ready;
	assign take = adv5 && fr.valid;

	// ---- configuration writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_period_q     <= X_PERIOD_RST;
			count_period_q <= COUNT_PERIOD_RST;
			z_period_q     <= Z_PERIOD_RST;
			count_limit_q  <= COUNT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_e'(cfg_index))
				REG_X_PERIOD:     x_period_q     <= cfg_wdata[XPER_W-1:0];
				REG_COUNT_PERIOD: count_period_q <= cfg_wdata[CPER_W-1:0];
				REG_Z_PERIOD:     z_period_q     <= cfg_wdata[ZPER_W-1:0];
				REG_COUNT_LIMIT:  count_limit_q  <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- limit to bcd: upper seven bits, then lower seven ----
	always_comb begin
		lim_c = (count_limit_q > CNT_MAX) ? CNT_MAX : count_limit_q;
		lim_acc_a = {13'b0, lim_c[13:11]};
		for (int i = 10; i >= 7; i--)
			lim_acc_a = dd_step(lim_acc_a, lim_c[i]);
		lim_acc_b = lim_hi_q;
		for (int i = 6; i >= 0; i--)
			lim_acc_b = dd_step(lim_acc_b, lim_lo_q[i]);
	end

	always_ff @(posedge clk) begin
		lim_bin_q <= lim_c;
		lim_hi_q  <= lim_acc_a;
		lim_lo_q  <= lim_c[6:0];
		lim_bcd_q <= lim_acc_b;
	end

	// ---- state update for the item leaving the front pipeline ----
	always_comb begin
		mode_n = mode_q;
		scan_n = scan_q;
		down_n = down_q;
		xpre_n = xpre_q;
		cpre_n = cpre_q;
		zpre_n = zpre_q;
		cnt_n  = cnt_q;
		cbcd_n = cbcd_q;
		xbcd_n = xbcd_q;
		zbcd_n = zbcd_q;

		x_next = {1'b0, xpre_q} + 11'd1;
		c_next = {1'b0, cpre_q} + 11'd1;
		z_next = {1'b0, zpre_q} + 12'd1;

		case (fr.op)
			OP_TICK: begin
				scan_n = scan_q + 2'd1;
				case (mode_q)
					MODE_X: begin
						// period zero or lowered below the count fires at once
						if (x_next >= {1'b0, x_period_q}) begin
							xpre_n = '0;
							xbcd_n = fr.x_bcd;
						end else begin
							xpre_n = x_next[XPER_W-1:0];
						end
					end
					MODE_Y: begin
						if (c_next >= {1'b0, count_period_q}) begin
							cpre_n = '0;
							if (!down_q) begin
								// above a lowered limit also wraps to zero
								if (cnt_q < lim_bin_q) begin
									cnt_n  = cnt_q + 14'd1;
									cbcd_n = bcd_inc(cbcd_q);
								end else begin
									cnt_n  = '0;
									cbcd_n = '0;
								end
							end else begin
								if (cnt_q != '0 && cnt_q <= lim_bin_q) begin
									cnt_n  = cnt_q - 14'd1;
									cbcd_n = bcd_dec(cbcd_q);
								end else begin
									cnt_n  = lim_bin_q;
									cbcd_n = lim_bcd_q;
								end
							end
						end else begin
							cpre_n = c_next[CPER_W-1:0];
						end
					end
					MODE_Z: begin
						if (z_next >= {1'b0, z_period_q}) begin
							zpre_n = '0;
							zbcd_n = fr.z_bcd;
						end else begin
							zpre_n = z_next[ZPER_W-1:0];
						end
					end
					default: ;
				endcase
			end
			OP_SEL_X:  mode_n = MODE_X;
			OP_SEL_Y:  mode_n = MODE_Y;
			OP_SEL_Z:  mode_n = MODE_Z;
			OP_TOGGLE: down_n = !down_q;
			// unused codes change nothing, the display is shown again
			default: ;
		endcase

		// glyph for the strobed digit, taken from the updated state
		case (mode_n)
			MODE_X: begin
				case (scan_n)
					2'd0:    seg_idx = {1'b0, xbcd_n[3:0]};
					2'd1:    seg_idx = {1'b0, xbcd_n[7:4]};
					2'd2:    seg_idx = SEG_DASH;
					default: seg_idx = SEG_A;
				endcase
			end
			MODE_Y:  seg_idx = {1'b0, cbcd_n[{scan_n, 2'b00} +: 4]};
			MODE_Z: begin
				case (scan_n)
					2'd0:    seg_idx = SEG_F;
					2'd1:    seg_idx = {1'b0, zbcd_n[3:0]};
					2'd2:    seg_idx = {1'b0, zbcd_n[7:4]};
					default: seg_idx = {1'b0, zbcd_n[11:8]};
				endcase
			end
			default: seg_idx = SEG_DASH;
		endcase

		// idle lights every digit with the dash
		den_n = (mode_n == MODE_IDLE) ? '0 : strobe_of(scan_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			scan_q <= '0;
			down_q <= 1'b0;
			xpre_q <= '0;
			cpre_q <= '0;
			zpre_q <= '0;
			cnt_q  <= '0;
			cbcd_q <= '0;
			xbcd_q <= '0;
			zbcd_q <= '0;
		end else if (take) begin
			mode_q <= mode_n;
			scan_q <= scan_n;
			down_q <= down_n;
			xpre_q <= xpre_n;
			cpre_q <= cpre_n;
			zpre_q <= zpre_n;
			cnt_q  <= cnt_n;
			cbcd_q <= cbcd_n;
			xbcd_q <= xbcd_n;
			zbcd_q <= zbcd_n;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_s5 <= 1'b0;
		else if (adv5)
			out_v_s5 <= fr.valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			den_s5  <= den_n;
			seg_s5  <= seg_of(seg_idx);
			mode_s5 <= mode_n;
		end
	end

	assign disp_ch.valid        = out_v_s5;
	assign disp_ch.digit_enable = den_s5;
	assign disp_ch.segments     = seg_s5;
	assign disp_ch.active_mode  = mode_s5;

	// ---- checks ----
	`MDCM_ALWAYS(a_cnt_range, cnt_q <= CNT_MAX, "counter above 9999")
	`MDCM_ALWAYS(a_cnt_bcd_digits, (cbcd_q[3:0] <= 4'd9) && (cbcd_q[7:4] <= 4'd9) && (cbcd_q[11:8] <= 4'd9) && (cbcd_q[15:12] <= 4'd9), "counter digit not decimal")
	`MDCM_NEXT(a_scan_hold, !take, $stable(scan_q), "scan moved without an item")
	`MDCM_NEXT(a_mode_hold, !take, $stable(mode_q), "mode moved without an item")

endmodule
